>>> rtl/core/n2kf_pkg.sv
// n2kf_pkg: shared types and constants of the fast-packet framer
// depends on nothing; imported by every module of the block

package n2kf_pkg;

	localparam logic [7:0] MAX_PAYLOAD = 8'd223;
	localparam logic [7:0] PDU2_START  = 8'd240;
	localparam logic [7:0] PAD_BYTE    = 8'hFF;
	localparam logic [7:0] FRAME_BYTES = 8'd8;
	localparam logic [3:0] FRAME_FULL  = 4'd8;
	localparam logic [3:0] FAST_FIRST_FILL = 4'd2;
	localparam int OPQ_DEPTH = 4;

	typedef struct packed {
		logic [2:0]  priority_req;
		logic [17:0] pgn;
		logic [7:0]  destination_address;
		logic [7:0]  source_address;
		logic [7:0]  payload_length;
		logic [7:0]  payload_byte;
	} req_t;

	typedef struct packed {
		logic [28:0] can_id;
		logic [3:0]  frame_length;
		logic [7:0]  data_byte0;
		logic [7:0]  data_byte1;
		logic [7:0]  data_byte2;
		logic [7:0]  data_byte3;
		logic [7:0]  data_byte4;
		logic [7:0]  data_byte5;
		logic [7:0]  data_byte6;
		logic [7:0]  data_byte7;
		logic        last_frame;
		logic        rejected;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_START,
		OP_DATA,
		OP_REJECT
	} op_kind_t;

	// classified byte handed from the front end to the frame assembler
	typedef struct packed {
		op_kind_t    kind;
		logic [28:0] id;
		logic [7:0]  len;
		logic [2:0]  seq;
		logic [7:0]  data;
		logic        last;
	} op_t;

endpackage

>>> rtl/core/n2kf_front.sv
// n2kf_front: message tracking, header sampling and identifier build
// depends on n2kf_pkg; feeds classified bytes into n2kf_opq

module n2kf_front import n2kf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  req_t       request,
	input  logic       cfg_write,
	input  logic [2:0] cfg_data,
	output logic       op_push,
	output op_t        op
);

	logic       in_msg_q;
	logic       drop_q;
	logic [7:0] remaining_q;
	logic [2:0] seq_q;

	logic        len_bad;
	logic [2:0]  seq_next;
	logic [28:0] id_c;
	logic [7:0]  rem_dec;

	always_comb begin
		len_bad  = (request.payload_length == 8'd0) || (request.payload_length > MAX_PAYLOAD);
		seq_next = seq_q + 3'd1;
		rem_dec  = remaining_q - 8'd1;
		id_c     = {request.priority_req, request.pgn, request.source_address};
		// pdu1 group with zero low byte: destination goes into the ps field
		if ((request.pgn[7:0] == 8'd0) && (request.pgn[15:8] < PDU2_START)) begin
			id_c[15:8] = id_c[15:8] | request.destination_address;
		end
	end

	always_comb begin
		op      = '0;
		op.id   = id_c;
		op.len  = request.payload_length;
		op.seq  = seq_next;
		op.data = request.payload_byte;
		op_push = 1'b0;
		if (!in_msg_q) begin
			op_push = accept;
			if (len_bad) begin
				op.kind = OP_REJECT;
			end else begin
				op.kind = OP_START;
				op.last = (request.payload_length == 8'd1);
			end
		end else if (!drop_q) begin
			op_push = accept;
			op.kind = OP_DATA;
			op.last = (rem_dec == 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q    <= 1'b0;
			drop_q      <= 1'b0;
			remaining_q <= 8'd0;
			seq_q       <= 3'd0;
		end else if (accept) begin
			if (!in_msg_q) begin
				remaining_q <= request.payload_length - 8'd1;
				if (len_bad) begin
					in_msg_q <= (request.payload_length > 8'd1);
					drop_q   <= (request.payload_length > 8'd1);
				end else begin
					seq_q    <= seq_next;
					in_msg_q <= (request.payload_length != 8'd1);
					drop_q   <= 1'b0;
				end
			end else begin
				remaining_q <= rem_dec;
				if (rem_dec == 8'd0) begin
					in_msg_q <= 1'b0;
					drop_q   <= 1'b0;
				end
			end
		end else if (cfg_write && !in_msg_q) begin
			seq_q <= cfg_data;
		end
	end

endmodule

>>> rtl/core/n2kf_opq.sv
// n2kf_opq: short queue of classified bytes between front end and assembler
// depends on n2kf_pkg for op_t and the queue depth

module n2kf_opq import n2kf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  op_t  wr_op,
	input  logic rd_en,
	output op_t  rd_op,
	output logic full,
	output logic empty
);

	localparam int PtrW = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
	localparam int CntW = $clog2(OPQ_DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(OPQ_DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(OPQ_DEPTH);

	op_t              slot_q [OPQ_DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CntFull);
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_op = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/n2kf_back.sv
// n2kf_back: frame assembler and result register
// depends on n2kf_pkg; drains n2kf_opq and presents finished frames

module n2kf_back import n2kf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic op_avail,
	input  op_t  op,
	output logic op_take,
	input  logic pop,
	output logic empty,
	output rsp_t result
);

	logic [7:0][7:0] fbuf_q;
	logic [3:0]      fill_q;
	logic            fast_q;
	logic [4:0]      idx_q;
	logic [2:0]      seq_q;
	logic [28:0]     id_q;
	logic            out_valid_q;
	rsp_t            out_q;

	logic            is_start;
	logic            fast_c;
	logic [2:0]      seq_c;
	logic [28:0]     id_c;
	logic [7:0][7:0] base_buf;
	logic [3:0]      base_fill;
	logic [7:0][7:0] wbuf;
	logic [3:0]      fill_new;
	logic            emit;
	logic [4:0]      idx_next;
	rsp_t            rsp_c;

	assign op_take = op_avail && (!out_valid_q || pop);
	assign empty   = !out_valid_q;
	assign result  = out_q;

	always_comb begin
		is_start  = (op.kind == OP_START);
		fast_c    = is_start ? (op.len > FRAME_BYTES) : fast_q;
		seq_c     = is_start ? op.seq : seq_q;
		id_c      = is_start ? op.id : id_q;
		idx_next  = idx_q + 5'd1;
		base_buf  = fbuf_q;
		base_fill = fill_q;
		if (is_start) begin
			base_buf  = {8{PAD_BYTE}};
			base_fill = 4'd0;
			if (fast_c) begin
				base_buf[0] = {op.seq, 5'd0};
				base_buf[1] = op.len;
				base_fill   = FAST_FIRST_FILL;
			end
		end
		wbuf                 = base_buf;
		wbuf[base_fill[2:0]] = op.data;
		fill_new             = base_fill + 4'd1;
		emit = (op.kind == OP_REJECT) || (fill_new == FRAME_FULL) || op.last;

		rsp_c = '0;
		if (op.kind == OP_REJECT) begin
			rsp_c.rejected = 1'b1;
		end else begin
			rsp_c.can_id       = id_c;
			rsp_c.frame_length = fast_c ? FRAME_FULL : fill_new;
			rsp_c.data_byte0   = wbuf[0];
			rsp_c.data_byte1   = wbuf[1];
			rsp_c.data_byte2   = wbuf[2];
			rsp_c.data_byte3   = wbuf[3];
			rsp_c.data_byte4   = wbuf[4];
			rsp_c.data_byte5   = wbuf[5];
			rsp_c.data_byte6   = wbuf[6];
			rsp_c.data_byte7   = wbuf[7];
			rsp_c.last_frame   = op.last;
		end
	end

	always_ff @(posedge clk) begin
		if (op_take && emit) begin
			out_q <= rsp_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fbuf_q      <= {8{PAD_BYTE}};
			fill_q      <= 4'd0;
			fast_q      <= 1'b0;
			idx_q       <= 5'd0;
			seq_q       <= 3'd0;
			id_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (op_take) begin
				out_valid_q <= emit || (out_valid_q && !pop);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (op_take && (op.kind != OP_REJECT)) begin
				seq_q  <= seq_c;
				id_q   <= id_c;
				if (!emit) begin
					fast_q <= fast_c;
					fbuf_q <= wbuf;
					fill_q <= fill_new;
					if (is_start) begin
						idx_q <= 5'd0;
					end
				end else if (op.last) begin
					fbuf_q <= {8{PAD_BYTE}};
					fill_q <= 4'd0;
					fast_q <= 1'b0;
					idx_q  <= 5'd0;
				end else begin
					// next fast-packet frame opens with sequence and index
					fast_q <= fast_c;
					fbuf_q <= {{7{PAD_BYTE}}, seq_c, (is_start ? 5'd1 : idx_next)};
					fill_q <= 4'd1;
					idx_q  <= is_start ? 5'd1 : idx_next;
				end
			end
		end
	end

endmodule

>>> rtl/core/n2k_fast_packet_framer_top.sv
// n2k_fast_packet_framer_top: top level of the fast-packet transmit framer
// depends on n2kf_pkg, n2kf_front, n2kf_opq and n2kf_back

// One payload byte is taken per transaction on the request side, with the
// message header sampled on the first byte of each message only. Messages of
// up to 8 bytes leave as a single frame; longer ones (up to 223 bytes) are cut
// into fast-packet frames whose first data byte holds the 3-bit sequence and
// 5-bit frame index, frame 0 also carrying the total length, the last frame
// padded with 0xff. A length of zero or above 223 yields one rejected result
// and the rest of that message is swallowed. The block takes one byte every
// cycle while the queue has room: the front end tracks message state and
// builds the identifier, a four-entry queue decouples it from the frame
// assembler, and the assembler writes finished frames into a single result
// register that is refilled in the same cycle it is popped. The final byte of
// a frame is registered in the queue, then in the result register. full only
// rises when the result side has been stalled long enough to fill the queue.
// The cfg channel is always ready; a write sets the start value of the
// sequence counter (the first message afterwards uses that value plus one)
// and is meant for idle periods only.

module n2k_fast_packet_framer_top import n2kf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  req_t       request,
	output logic       empty,
	input  logic       pop,
	output rsp_t       result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_data
);

	logic accept;
	logic op_push;
	op_t  op_in;
	op_t  op_out;
	logic opq_empty;
	logic op_take;

	// request transaction completes whenever the queue has room
	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	n2kf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.request   (request),
		.cfg_write (cfg_valid),
		.cfg_data  (cfg_data),
		.op_push   (op_push),
		.op        (op_in)
	);

	n2kf_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (op_push),
		.wr_op  (op_in),
		.rd_en  (op_take),
		.rd_op  (op_out),
		.full   (full),
		.empty  (opq_empty)
	);

	n2kf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_avail (!opq_empty),
		.op       (op_out),
		.op_take  (op_take),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

>>> dv/n2kf_frame_ledger_pkg.sv
// n2kf_frame_ledger_pkg: expected-frame ledger of the fast-packet framer bench
// depends on n2kf_pkg for req_t, rsp_t and the framing constants

package n2kf_frame_ledger_pkg;
	import n2kf_pkg::*;

	class fast_packet_ledger;
		rsp_t        due_frames[$];
		int          mismatches;
		logic [2:0]  start_seq;
		logic [2:0]  seq_count;
		logic        in_msg;
		logic        dropping;
		logic        fast;
		logic [7:0]  remaining;
		logic [4:0]  frame_idx;
		logic [3:0]  fill;
		logic [7:0]  frame_data[8];
		logic [28:0] ident;

		function new();
			mismatches = 0;
			start_seq  = '0;
			seq_count  = '0;
			in_msg     = 1'b0;
			dropping   = 1'b0;
			fast       = 1'b0;
			remaining  = '0;
			frame_idx  = '0;
			fill       = '0;
			ident      = '0;
			clear_frame();
		endfunction

		function void clear_frame();
			foreach (frame_data[k])
				frame_data[k] = PAD_BYTE;
		endfunction

		// counter is only reloaded between messages
		function void load_start_seq(logic [2:0] v);
			start_seq = v;
			if (!in_msg)
				seq_count = v;
		endfunction

		// works out the frame, if any, that one accepted byte completes
		function void take_byte(req_t r);
			rsp_t f;
			f = '0;
			if (!in_msg) begin
				if (r.payload_length == 8'd0 || r.payload_length > MAX_PAYLOAD) begin
					f.rejected = 1'b1;
					due_frames.push_back(f);
					if (r.payload_length > 8'd1) begin
						in_msg    = 1'b1;
						dropping  = 1'b1;
						remaining = r.payload_length - 8'd1;
					end
					return;
				end
				seq_count = seq_count + 3'd1;
				ident = {r.priority_req, r.pgn, r.source_address};
				if (r.pgn[7:0] == 8'd0 && r.pgn[15:8] < PDU2_START)
					ident[15:8] = ident[15:8] | r.destination_address;
				clear_frame();
				fast      = r.payload_length > FRAME_BYTES;
				dropping  = 1'b0;
				frame_idx = '0;
				if (fast) begin
					frame_data[0] = {seq_count, 5'd0};
					frame_data[1] = r.payload_length;
					fill = FAST_FIRST_FILL;
				end else begin
					fill = '0;
				end
				remaining = r.payload_length;
				in_msg    = 1'b1;
			end else if (dropping) begin
				remaining = remaining - 8'd1;
				if (remaining == 8'd0) begin
					in_msg   = 1'b0;
					dropping = 1'b0;
				end
				return;
			end

			frame_data[fill[2:0]] = r.payload_byte;
			fill      = fill + 4'd1;
			remaining = remaining - 8'd1;
			if (fill < FRAME_FULL && remaining != 8'd0)
				return;

			f.can_id       = ident;
			f.frame_length = fast ? FRAME_FULL : fill;
			f.data_byte0   = frame_data[0];
			f.data_byte1   = frame_data[1];
			f.data_byte2   = frame_data[2];
			f.data_byte3   = frame_data[3];
			f.data_byte4   = frame_data[4];
			f.data_byte5   = frame_data[5];
			f.data_byte6   = frame_data[6];
			f.data_byte7   = frame_data[7];
			f.last_frame   = (remaining == 8'd0);
			due_frames.push_back(f);

			clear_frame();
			if (remaining == 8'd0) begin
				in_msg    = 1'b0;
				fast      = 1'b0;
				fill      = '0;
				frame_idx = '0;
			end else begin
				frame_idx     = frame_idx + 5'd1;
				frame_data[0] = {seq_count, frame_idx};
				fill          = 4'd1;
			end
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			if (mismatches <= 100)
				$display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
		endtask

		task check_field(string what, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report(what, got, want);
		endtask

		task check_frame(rsp_t got);
			rsp_t want;
			if (due_frames.size() == 0) begin
				report("frame with nothing due, can_id", 32'(got.can_id), '0);
				return;
			end
			want = due_frames.pop_front();
			check_field("can_id", 32'(got.can_id), 32'(want.can_id));
			check_field("frame_length", 32'(got.frame_length), 32'(want.frame_length));
			check_field("data_byte0", 32'(got.data_byte0), 32'(want.data_byte0));
			check_field("data_byte1", 32'(got.data_byte1), 32'(want.data_byte1));
			check_field("data_byte2", 32'(got.data_byte2), 32'(want.data_byte2));
			check_field("data_byte3", 32'(got.data_byte3), 32'(want.data_byte3));
			check_field("data_byte4", 32'(got.data_byte4), 32'(want.data_byte4));
			check_field("data_byte5", 32'(got.data_byte5), 32'(want.data_byte5));
			check_field("data_byte6", 32'(got.data_byte6), 32'(want.data_byte6));
			check_field("data_byte7", 32'(got.data_byte7), 32'(want.data_byte7));
			check_field("last_frame", 32'(got.last_frame), 32'(want.last_frame));
			check_field("rejected", 32'(got.rejected), 32'(want.rejected));
		endtask

		task close_out();
			if (due_frames.size() != 0)
				report("frames never delivered", 32'(due_frames.size()), '0);
		endtask
	endclass

endpackage

>>> dv/testbench.sv
// testbench: self-checking bench of the fast-packet transmit framer
// depends on n2kf_pkg, n2kf_frame_ledger_pkg and n2k_fast_packet_framer_top

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import n2kf_pkg::*;
	import n2kf_frame_ledger_pkg::*;

	localparam int PHASE_ITEMS   = 475;
	localparam int LIMIT_CYCLES  = 200000;
	localparam int HOLD_AT_FRAME = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_LIMIT   = 20000;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	req_t       request;
	logic       empty;
	logic       pop;
	rsp_t       result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_data;

	fast_packet_ledger ledger = new();
	int items_sent  = 0;
	int frames_seen = 0;
	int cycles      = 0;

	n2k_fast_packet_framer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic req_t make_header(logic [2:0] prio, logic [17:0] pgn, logic [7:0] dst,
			logic [7:0] src, logic [7:0] len, logic [7:0] first_byte);
		req_t r;
		r.priority_req        = prio;
		r.pgn                 = pgn;
		r.destination_address = dst;
		r.source_address      = src;
		r.payload_length      = len;
		r.payload_byte        = first_byte;
		return r;
	endfunction

	function automatic req_t random_request();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	// one request transaction; called and left at a falling edge
	task automatic send_item(input req_t r);
		// random gaps, but none in a steady stretch of the run
		while ((items_sent < 900 || items_sent >= 1200) && $urandom_range(0, 99) < 16) begin
			push = 1'b0;
			@(negedge clk);
		end
		push    = 1'b1;
		request = r;
		do @(posedge clk); while (full);
		ledger.take_byte(r);
		items_sent++;
		@(negedge clk);
	endtask

	// header rides on the first byte only; later bytes carry random header noise
	task automatic send_message(input req_t hdr);
		int n;
		n = (hdr.payload_length == 8'd0) ? 1 : int'(hdr.payload_length);
		send_item(hdr);
		for (int i = 1; i < n; i++)
			send_item(random_request());
	endtask

	task automatic send_random_message();
		req_t hdr;
		int   pick;
		hdr  = random_request();
		pick = $urandom_range(0, 3);
		// steer the group number across pdu1 with destination, pdu2 and odd low bytes
		case (pick)
			0: hdr.pgn[15:0] = {8'($urandom_range(0, 239)), 8'h00};
			1: hdr.pgn[15:0] = {8'($urandom_range(240, 255)), 8'h00};
			2: hdr.pgn[7:0]  = 8'($urandom_range(1, 255));
			default: ;
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 45)
			hdr.payload_length = 8'($urandom_range(1, 8));
		else if (pick < 85)
			hdr.payload_length = 8'($urandom_range(9, 40));
		else if (pick < 88)
			hdr.payload_length = 8'($urandom_range(41, 222));
		else if (pick < 89)
			hdr.payload_length = MAX_PAYLOAD;
		else if (pick < 96)
			hdr.payload_length = 8'd0;
		else if (pick < 97)
			hdr.payload_length = 8'($urandom_range(224, 255));
		else
			// last fast-packet frame exactly full
			hdr.payload_length = 8'(6 + 7 * $urandom_range(1, 5));
		send_message(hdr);
	endtask

	// cfg transaction; only issued while the block is idle
	task automatic write_start_seq(input logic [2:0] v);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		ledger.load_start_seq(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// wait for outstanding frames, then give swallowed bytes time to drain
	task automatic settle();
		int waited;
		waited = 0;
		push = 1'b0;
		while (ledger.due_frames.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// result side: random stalls, one long hold-off and a steady stretch
	initial begin : drain
		bit held;
		held = 1'b0;
		pop  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held && frames_seen >= HOLD_AT_FRAME) begin
				// hold off long enough for the queue to fill and full to rise
				held = 1'b1;
				pop  = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (frames_seen >= 120 && frames_seen < 200)
				pop = 1'b1;
			else
				pop = ($urandom_range(0, 99) >= 16);
			@(posedge clk);
			if (pop && !empty) begin
				ledger.check_frame(result);
				frames_seen++;
			end
		end
	end

	initial begin : stimulus
		logic [2:0] seq_settings[4];
		int phase_end;

		arst_n    = 1'b0;
		push      = 1'b0;
		request   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, counter at its reset value
		// zero length rejected, header fields at their top values
		send_message(make_header(3'd7, 18'h3FFFF, 8'hFF, 8'hFF, 8'd0, 8'hFF));
		// single byte, pdu1 at the top of its range, destination ored in
		send_message(make_header(3'd0, {2'b00, 8'd239, 8'h00}, 8'hFF, 8'h00, 8'd1, 8'h00));
		// first pdu2 group, destination ignored
		send_message(make_header(3'd7, {2'b11, 8'd240, 8'h00}, 8'hA5, 8'hFF, 8'd2, 8'hFF));
		// full single frame, low byte nonzero so no destination
		send_message(make_header(3'd3, 18'h1EF12, 8'h5A, 8'h80, FRAME_BYTES, 8'h7F));
		// shortest fast-packet message: six bytes in frame 0, three in frame 1
		send_message(make_header(3'd6, 18'h0EA00, 8'h00, 8'h01, 8'd9, 8'h80));
		settle();

		// random phases, each with its own start value of the sequence counter
		seq_settings = '{3'd7, 3'd0, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
		foreach (seq_settings[p]) begin
			write_start_seq(seq_settings[p]);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				send_random_message();
			settle();
		end

		ledger.close_out();
		if (ledger.mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
